// ===== rtl/word_clock_lamp_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// word_clock_lamp_decoder_assert
// Assertion macros for the word clock lamp decoder.
// ----------------------------------------------------------------------------
`ifndef WORD_CLOCK_LAMP_DECODER_ASSERT_SVH
`define WORD_CLOCK_LAMP_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WCLD_ASSERT_NOW(label, clk, rstn, cond, impl, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (impl)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WCLD_ASSERT_NEXT(label, clk, rstn, cond, impl, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (impl)) \
        else $error(msg);

`endif

// ===== rtl/wcld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcld_pkg
// Types, register map and helpers shared by the word clock lamp decoder.
// ----------------------------------------------------------------------------
package wcld_pkg;

    localparam int unsigned LAMP_COLS = 11;
    localparam int unsigned GRID_ROWS = 9;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    // register index (byte address / 4)
    localparam logic REG_LANGUAGE = 1'b0;

    localparam logic LANG_GERMAN  = 1'b0;
    localparam logic LANG_ENGLISH = 1'b1;

    typedef logic [LAMP_COLS-1:0] lamps_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
    } wcld_in_t;

    typedef struct packed {
        lamps_t header_lamps;
        lamps_t row0_lamps;
        lamps_t row1_lamps;
        lamps_t row2_lamps;
        lamps_t row3_lamps;
        lamps_t row4_lamps;
        lamps_t row5_lamps;
        lamps_t row6_lamps;
        lamps_t row7_lamps;
        lamps_t row8_lamps;
    } wcld_out_t;

    // lamps lo..hi lit, inclusive
    function automatic lamps_t lamp_span(input int unsigned lo, input int unsigned hi);
        lamps_t m;
        m = '0;
        for (int unsigned i = 0; i < LAMP_COLS; i++) begin
            m[i] = (i >= lo) && (i <= hi);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/word_clock_lamp_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// word_clock_lamp_decoder
// Turns an hour and minute into the lamp masks of a German or English
// 9x11 word clock grid plus its header row.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one time item (hour, minute) per valid/ready handshake.
//   m_ channel returns one lamp item per input item, in order.
//   The APB port holds the language register (address 0, bit 0):
//   0 selects the German grid, 1 the English grid. Change it only while
//   no item is in flight.
// Timing:
//   Two register stages: an input register and a result register with the
//   word decode between them. An accepted input is held in the input
//   register, then its decoded result in the result register; throughput
//   is one item per cycle while m_ready is high, set by the single decode stage.
// Reset:
//   aresetn (synchronous, active low) empties both stages and sets the
//   language to German.
// Stall:
//   when m_ready is low the result register holds, the input register fills,
//   and s_ready drops only once both stages are occupied.
// ----------------------------------------------------------------------------
module word_clock_lamp_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire wcld_pkg::wcld_in_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output wcld_pkg::wcld_out_t                    m_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wcld_pkg::APB_AW-1:0]       paddr,
    input  wire logic [wcld_pkg::APB_DW-1:0]       pwdata,
    output logic [wcld_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import wcld_pkg::*;

    logic      language_reg, language_next;
    logic      s1_valid_reg, s1_valid_next;
    wcld_in_t  s1_data_reg, s1_data_next;
    logic      m_valid_reg, m_valid_next;
    wcld_out_t m_data_reg, m_data_next;

    logic      m_take;
    logic      cfg_write;

    logic [5:0] min_sat;
    logic [9:0] min_x13;
    logic [3:0] blk;
    logic [3:0] h12;
    logic [3:0] h12_next;
    logic [3:0] h_show;
    logic [3:0] en_mins;
    lamps_t     g [GRID_ROWS];

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        language_next = language_reg;
        if (cfg_write && (paddr[2] == REG_LANGUAGE)) begin
            language_next = pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LANGUAGE) begin
            prdata[0] = language_reg;
        end
    end

    // ---------------- handshake ----------------
    assign m_take  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || m_take;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_data_next  = s1_data_reg;
        if (s_ready) begin
            s1_valid_next = s_valid;
            s1_data_next  = s_data;
        end
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_take) begin
            m_valid_next = s1_valid_reg;
            m_data_next.header_lamps = (language_reg == LANG_ENGLISH) ?
                                       (lamp_span(0, 1) | lamp_span(3, 4)) :
                                       (lamp_span(0, 1) | lamp_span(3, 5));
            m_data_next.row0_lamps = g[0];
            m_data_next.row1_lamps = g[1];
            m_data_next.row2_lamps = g[2];
            m_data_next.row3_lamps = g[3];
            m_data_next.row4_lamps = g[4];
            m_data_next.row5_lamps = g[5];
            m_data_next.row6_lamps = g[6];
            m_data_next.row7_lamps = g[7];
            m_data_next.row8_lamps = g[8];
        end
    end

    // ---------------- decode ----------------
    // minute / 5 as (minute * 13) >> 6, exact for 0..59
    assign min_sat = (s1_data_reg.minute > 6'd59) ? 6'd59 : s1_data_reg.minute;
    assign min_x13 = {4'd0, min_sat} * 10'd13;
    assign blk     = min_x13[9:6];

    always_comb begin
        if (s1_data_reg.hour >= 5'd24) begin
            h12 = 4'(s1_data_reg.hour - 5'd24);
        end else if (s1_data_reg.hour >= 5'd12) begin
            h12 = 4'(s1_data_reg.hour - 5'd12);
        end else begin
            h12 = s1_data_reg.hour[3:0];
        end
    end

    assign h12_next = (h12 == 4'd11) ? 4'd0 : h12 + 4'd1;
    assign en_mins  = (blk <= 4'd6) ? blk : 4'd12 - blk;

    always_comb begin
        for (int r = 0; r < GRID_ROWS; r++) begin
            g[r] = '0;
        end
        h_show = h12;
        if (language_reg == LANG_GERMAN) begin
            unique case (blk)
                4'd1:  begin g[1] |= lamp_span(0, 3);  g[2] |= lamp_span(7, 10); end
                4'd2:  begin g[0] |= lamp_span(0, 3);  g[2] |= lamp_span(7, 10); end
                4'd3:  begin g[1] |= lamp_span(4, 10); g[2] |= lamp_span(7, 10); end
                4'd4:  begin g[0] |= lamp_span(4, 10); g[2] |= lamp_span(7, 10); end
                4'd5:  begin
                    g[1] |= lamp_span(0, 3);
                    g[2] |= lamp_span(0, 2);
                    g[3] |= lamp_span(0, 3);
                end
                4'd6:  begin g[3] |= lamp_span(0, 3); end
                4'd7:  begin
                    g[1] |= lamp_span(0, 3);
                    g[2] |= lamp_span(7, 10);
                    g[3] |= lamp_span(0, 3);
                end
                4'd8:  begin g[0] |= lamp_span(4, 10); g[2] |= lamp_span(0, 2); end
                4'd9:  begin g[1] |= lamp_span(4, 10); g[2] |= lamp_span(0, 2); end
                4'd10: begin g[0] |= lamp_span(0, 3);  g[2] |= lamp_span(0, 2); end
                4'd11: begin g[1] |= lamp_span(0, 3);  g[2] |= lamp_span(0, 2); end
                default: begin end
            endcase
            // from twenty-five past the next hour is named
            if (blk >= 4'd5) begin
                h_show = h12_next;
            end
            unique case (h_show)
                4'd0:  g[7] |= lamp_span(6, 10);
                4'd1:  g[4] |= (blk == 4'd0) ? lamp_span(0, 2) : lamp_span(0, 3);
                4'd2:  g[4] |= lamp_span(7, 10);
                4'd3:  g[5] |= lamp_span(0, 3);
                4'd4:  g[5] |= lamp_span(7, 10);
                4'd5:  g[3] |= lamp_span(7, 10);
                4'd6:  g[6] |= lamp_span(0, 4);
                4'd7:  g[7] |= lamp_span(0, 5);
                4'd8:  g[6] |= lamp_span(7, 10);
                4'd9:  g[8] |= lamp_span(3, 6);
                4'd10: g[8] |= lamp_span(0, 3);
                default: g[3] |= lamp_span(5, 7);
            endcase
            if (blk == 4'd0) begin
                g[8] |= lamp_span(8, 10);
            end
        end else begin
            unique case (en_mins)
                4'd1:  g[1] |= lamp_span(6, 9);
                4'd2:  g[2] |= lamp_span(5, 7);
                4'd3:  g[0] |= lamp_span(2, 8);
                4'd4:  g[1] |= lamp_span(0, 5);
                4'd5:  g[1] |= lamp_span(0, 9);
                4'd6:  g[2] |= lamp_span(0, 3);
                default: begin end
            endcase
            // oclock, past or to
            priority if (blk == 4'd0) begin
                g[8] |= lamp_span(5, 10);
            end else if (blk <= 4'd6) begin
                g[3] |= lamp_span(0, 3);
            end else begin
                g[2] |= lamp_span(9, 10);
                h_show = h12_next;
            end
            unique case (h_show)
                4'd0:  g[7] |= lamp_span(5, 10);
                4'd1:  g[4] |= lamp_span(0, 2);
                4'd2:  g[5] |= lamp_span(8, 10);
                4'd3:  g[4] |= lamp_span(6, 10);
                4'd4:  g[5] |= lamp_span(0, 3);
                4'd5:  g[5] |= lamp_span(4, 7);
                4'd6:  g[4] |= lamp_span(3, 5);
                4'd7:  g[7] |= lamp_span(0, 4);
                4'd8:  g[6] |= lamp_span(0, 4);
                4'd9:  g[3] |= lamp_span(7, 10);
                4'd10: g[8] |= lamp_span(0, 2);
                default: g[6] |= lamp_span(5, 10);
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            language_reg <= LANG_GERMAN;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            language_reg <= language_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_data_reg <= s1_data_next;
        m_data_reg  <= m_data_next;
    end

    // ---------------- assertions ----------------
`include "word_clock_lamp_decoder_assert.svh"

    `WCLD_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !s1_valid_reg, s_ready,
                     "input stage empty but not ready")
    `WCLD_ASSERT_NEXT(a_stage_advance, aclk, aresetn, s1_valid_reg && m_take, m_valid_reg,
                      "decoded item lost between stages")
    `WCLD_ASSERT_NOW(a_header_lit, aclk, aresetn, m_valid_reg,
                     (m_data_reg.header_lamps[1:0] == 2'b11) &&
                     (m_data_reg.header_lamps[4:3] == 2'b11),
                     "header words not lit")

endmodule
`default_nettype wire

// ===== bench/word_clock_lamp_decoder_test.sv =====
// ----------------------------------------------------------------------------
// word_clock_lamp_decoder_test
// Drives hour/minute items into the decoder under both grid languages, with
// bursty input and a stalling output side, and checks every lamp item against
// an in-bench prediction of the German and English word patterns.
// ----------------------------------------------------------------------------
module word_clock_lamp_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wcld_pkg::*;

    localparam int OUT_W         = $bits(wcld_out_t);
    localparam int NUM_FIELDS    = GRID_ROWS + 1;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 255;
    localparam logic [APB_AW-1:0] LANGUAGE_ADDR = APB_AW'(4 * int'(REG_LANGUAGE));

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    wcld_in_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    wcld_out_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic      grid_lang = LANG_GERMAN;
    wcld_out_t expected_lamps[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;
    int        ready_mode  = 0;
    int        mode_left   = 0;
    int        stall_phase = 0;

    word_clock_lamp_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // lit columns lo..hi
    function automatic lamps_t cols(input int unsigned lo, input int unsigned hi);
        logic [31:0] m;
        m = ((32'd1 << (hi + 1)) - 32'd1) & ~((32'd1 << lo) - 32'd1);
        return m[LAMP_COLS-1:0];
    endfunction

    function automatic wcld_out_t lamps_for_time(input logic lang, input wcld_in_t t);
        lamps_t      row [GRID_ROWS];
        wcld_out_t   r;
        int unsigned mn;
        int unsigned blk;
        int unsigned away_mins;
        int unsigned h12;
        mn  = (t.minute > 6'd59) ? 59 : int'(t.minute);
        blk = (mn / 5) * 5;
        foreach (row[i]) row[i] = '0;
        if (lang == LANG_ENGLISH) begin
            r.header_lamps = cols(0, 1) | cols(3, 4);
            away_mins = (blk <= 30) ? blk : 60 - blk;
            case (away_mins)
                5:  row[1] |= cols(6, 9);
                10: row[2] |= cols(5, 7);
                15: row[0] |= cols(2, 8);
                20: row[1] |= cols(0, 5);
                25: row[1] |= cols(0, 9);
                30: row[2] |= cols(0, 3);
                default: ;
            endcase
            if (blk == 0) begin
                row[8] |= cols(5, 10);
            end else if (blk <= 30) begin
                row[3] |= cols(0, 3);
            end else begin
                row[2] |= cols(9, 10);
            end
            // after half past the next hour is named
            h12 = (int'(t.hour) + ((blk > 30) ? 1 : 0)) % 12;
            case (h12)
                0:  row[7] |= cols(5, 10);
                1:  row[4] |= cols(0, 2);
                2:  row[5] |= cols(8, 10);
                3:  row[4] |= cols(6, 10);
                4:  row[5] |= cols(0, 3);
                5:  row[5] |= cols(4, 7);
                6:  row[4] |= cols(3, 5);
                7:  row[7] |= cols(0, 4);
                8:  row[6] |= cols(0, 4);
                9:  row[3] |= cols(7, 10);
                10: row[8] |= cols(0, 2);
                default: row[6] |= cols(5, 10);
            endcase
        end else begin
            r.header_lamps = cols(0, 1) | cols(3, 5);
            case (blk)
                5:  begin row[1] |= cols(0, 3); row[2] |= cols(7, 10); end
                10: begin row[0] |= cols(0, 3); row[2] |= cols(7, 10); end
                15: begin row[1] |= cols(4, 10); row[2] |= cols(7, 10); end
                20: begin row[0] |= cols(4, 10); row[2] |= cols(7, 10); end
                25: begin
                    row[1] |= cols(0, 3);
                    row[2] |= cols(0, 2);
                    row[3] |= cols(0, 3);
                end
                30: row[3] |= cols(0, 3);
                35: begin
                    row[1] |= cols(0, 3);
                    row[2] |= cols(7, 10);
                    row[3] |= cols(0, 3);
                end
                40: begin row[0] |= cols(4, 10); row[2] |= cols(0, 2); end
                45: begin row[1] |= cols(4, 10); row[2] |= cols(0, 2); end
                50: begin row[0] |= cols(0, 3); row[2] |= cols(0, 2); end
                55: begin row[1] |= cols(0, 3); row[2] |= cols(0, 2); end
                default: ;
            endcase
            // from five to half on, the next hour is named
            h12 = (int'(t.hour) + ((blk >= 25) ? 1 : 0)) % 12;
            case (h12)
                0:  row[7] |= cols(6, 10);
                1:  row[4] |= cols(0, (blk == 0) ? 2 : 3);
                2:  row[4] |= cols(7, 10);
                3:  row[5] |= cols(0, 3);
                4:  row[5] |= cols(7, 10);
                5:  row[3] |= cols(7, 10);
                6:  row[6] |= cols(0, 4);
                7:  row[7] |= cols(0, 5);
                8:  row[6] |= cols(7, 10);
                9:  row[8] |= cols(3, 6);
                10: row[8] |= cols(0, 3);
                default: row[3] |= cols(5, 7);
            endcase
            if (blk == 0) begin
                row[8] |= cols(8, 10);
            end
        end
        r.row0_lamps = row[0];
        r.row1_lamps = row[1];
        r.row2_lamps = row[2];
        r.row3_lamps = row[3];
        r.row4_lamps = row[4];
        r.row5_lamps = row[5];
        r.row6_lamps = row[6];
        r.row7_lamps = row[7];
        r.row8_lamps = row[8];
        return r;
    endfunction

    task automatic send_time(input int unsigned hr, input int unsigned mn);
        wcld_in_t    item;
        int unsigned gap;
        item.hour   = 5'(hr);
        item.minute = 6'(mn);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        expected_lamps.push_back(lamps_for_time(grid_lang, item));
    endtask

    // drop valid and wait until every lamp item has come back
    task automatic quiesce();
        s_valid <= 1'b0;
        while (expected_lamps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_language(input logic lang);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LANGUAGE_ADDR;
        pwdata  <= APB_DW'(lang);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        grid_lang = lang;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[0] !== lang) begin
            $display("%0t: language readback expected %0b, got %0b", $time, lang, prdata[0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_language();
        send_time(1, 0);
        send_time(12, 33);
        quiesce();
    endtask

    task automatic test_german_phrases();
        write_language(LANG_GERMAN);
        send_time(0, 0);
        send_time(1, 0);
        send_time(13, 4);
        send_time(5, 25);
        send_time(6, 30);
        send_time(11, 35);
        send_time(7, 45);
        send_time(23, 59);
        send_time(31, 63);
        send_time(24, 60);
        quiesce();
    endtask

    task automatic test_english_phrases();
        write_language(LANG_ENGLISH);
        send_time(0, 0);
        send_time(12, 5);
        send_time(4, 20);
        send_time(9, 30);
        send_time(10, 34);
        send_time(11, 35);
        send_time(23, 55);
        send_time(31, 62);
        send_time(24, 63);
        quiesce();
    endtask

    task automatic test_random_times();
        int unsigned hr;
        int unsigned mn;
        int          pause_at;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_language((phase % 2 == 0) ? LANG_GERMAN : LANG_ENGLISH);
            pause_at = $urandom_range(40, PHASE_ITEMS - 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at) begin
                    quiesce();
                end
                hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
                case ($urandom_range(0, 9))
                    0: mn = $urandom_range(60, 63);
                    1: mn = $urandom_range(0, 63);
                    2: mn = 5 * $urandom_range(0, 11);
                    default: mn = $urandom_range(0, 59);
                endcase
                send_time(hr, mn);
            end
            quiesce();
        end
    endtask

    // output side switches between randomly chosen ready modes, from always ready to mostly stalled
    always @(posedge aclk) begin
        stall_phase <= (stall_phase + 1) % 13;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 160);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (stall_phase < 9);
        endcase
    end

    always @(posedge aclk) begin : check_lamps
        wcld_out_t        want;
        logic [OUT_W-1:0] want_bits;
        logic [OUT_W-1:0] got_bits;
        string            fname;
        if (aresetn && m_valid && m_ready) begin
            if (expected_lamps.size() == 0) begin
                $display("%0t: lamp item with none expected, got %h", $time, m_data);
                error_count++;
            end else begin
                want      = expected_lamps.pop_front();
                want_bits = want;
                got_bits  = m_data;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    if (got_bits[OUT_W-1-LAMP_COLS*i -: LAMP_COLS]
                            !== want_bits[OUT_W-1-LAMP_COLS*i -: LAMP_COLS]) begin
                        if (i == 0) begin
                            fname = "header_lamps";
                        end else begin
                            fname = $sformatf("row%0d_lamps", i - 1);
                        end
                        $display("%0t: %s expected %03h, got %03h", $time, fname,
                                 want_bits[OUT_W-1-LAMP_COLS*i -: LAMP_COLS],
                                 got_bits[OUT_W-1-LAMP_COLS*i -: LAMP_COLS]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("word_clock_lamp_decoder_test: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_language();
        test_german_phrases();
        test_english_phrases();
        test_random_times();
        if (error_count == 0) begin
            $display("word_clock_lamp_decoder_test: done, clean");
        end else begin
            $display("word_clock_lamp_decoder_test: done, errors");
        end
        $finish;
    end

endmodule
